// ===== sv/bc1d_pkg.sv =====
// Shared types and endpoint arithmetic for the BC1 block decoder.
`timescale 1ns / 1ps
`default_nettype none

package bc1d_pkg;

	typedef struct packed {
		logic [3:0][31:0] pal;
		logic [31:0]      sel;
		logic [12:0]      x0;
		logic [12:0]      y0;
		logic [3:0]       mask;
		logic [2:0]       nrows;
	} bc1d_entry_t;

	// 5-bit channel to 8 bits, rounded: 8v + floor((7v + 15) / 31)
	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [7:0]  y;
		logic [16:0] p;
		y = 8'({3'b000, v} * 8'd7) + 8'd15;
		p = {9'b0, y} * 17'd265;
		return {v, 3'b000} + {5'b00000, p[15:13]};
	endfunction

	// 6-bit channel to 8 bits, rounded: 4v + floor((3v + 31) / 63)
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [7:0]  y;
		logic [16:0] p;
		y = 8'({2'b00, v} * 8'd3) + 8'd31;
		p = {9'b0, y} * 17'd261;
		return {v, 2'b00} + {6'b000000, p[15:14]};
	endfunction

	// floor(x / 3) for x up to 765
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [18:0] p;
		p = {9'b0, x} * 19'd683;
		return p[18:11];
	endfunction

endpackage

`default_nettype wire

// ===== sv/bc1d_front.sv =====
// Front end: takes a block word, widens the endpoints, builds the palette, column mask and row count.
`timescale 1ns / 1ps
`default_nettype none

module bc1d_front
	import bc1d_pkg::*;
#(
	parameter int unsigned MAX_DIM = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] endpoint_a,
	input  wire logic [15:0] endpoint_b,
	input  wire logic [31:0] selector_bits,
	input  wire logic [10:0] block_col,
	input  wire logic [10:0] block_row,
	input  wire logic [13:0] width_cfg,
	input  wire logic [13:0] height_cfg,
	output bc1d_entry_t      q_data,
	output logic             q_push,
	input  wire logic        q_full
);

	localparam int unsigned DimW = $clog2(MAX_DIM + 1);
	localparam int unsigned CmpW = (DimW > 14) ? DimW : 14;
	localparam logic [CmpW-1:0] DimMax = CmpW'(MAX_DIM);

	logic            accept;
	logic            valid_s1;
	logic [2:0][7:0] a_s1;
	logic [2:0][7:0] b_s1;
	logic            gt_s1;
	logic [31:0]     sel_s1;
	logic [12:0]     x0_s1;
	logic [12:0]     y0_s1;

	logic [2:0][7:0] a_w;
	logic [2:0][7:0] b_w;
	logic [CmpW-1:0] w_ext;
	logic [CmpW-1:0] h_ext;
	logic [CmpW-1:0] w_lim;
	logic [CmpW-1:0] h_lim;
	logic [3:0]      mask;
	logic [3:0]      row_in;
	logic [2:0][7:0] m_ch;
	logic [2:0][7:0] n_ch;
	logic [3:0][31:0] pal;

	assign accept = push & ~full;
	assign full   = valid_s1 & q_full;
	assign q_push = valid_s1 & ~q_full;

	assign a_w[0] = widen5(endpoint_a[15:11]);
	assign a_w[1] = widen6(endpoint_a[10:5]);
	assign a_w[2] = widen5(endpoint_a[4:0]);
	assign b_w[0] = widen5(endpoint_b[15:11]);
	assign b_w[1] = widen6(endpoint_b[10:5]);
	assign b_w[2] = widen5(endpoint_b[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept | (valid_s1 & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1   <= a_w;
			b_s1   <= b_w;
			gt_s1  <= endpoint_a > endpoint_b;
			sel_s1 <= selector_bits;
			x0_s1  <= {block_col, 2'b00};
			y0_s1  <= {block_row, 2'b00};
		end
	end

	// saturate the image size to the largest supported dimension
	always_comb begin
		w_ext = CmpW'(width_cfg);
		h_ext = CmpW'(height_cfg);
		w_lim = (w_ext > DimMax) ? DimMax : w_ext;
		h_lim = (h_ext > DimMax) ? DimMax : h_ext;
		for (int i = 0; i < 4; i++) begin
			mask[i]   = CmpW'(14'({1'b0, x0_s1}) + 14'(i)) < w_lim;
			row_in[i] = CmpW'(14'({1'b0, y0_s1}) + 14'(i)) < h_lim;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (gt_s1) begin
				m_ch[c] = div3({1'b0, a_s1[c], 1'b0} + {2'b00, b_s1[c]});
				n_ch[c] = div3({2'b00, a_s1[c]} + {1'b0, b_s1[c], 1'b0});
			end else begin
				m_ch[c] = 8'(({1'b0, a_s1[c]} + {1'b0, b_s1[c]}) >> 1);
				n_ch[c] = 8'd0;
			end
		end
		pal[0] = {8'hFF, a_s1[2], a_s1[1], a_s1[0]};
		pal[1] = {8'hFF, b_s1[2], b_s1[1], b_s1[0]};
		pal[2] = {8'hFF, m_ch[2], m_ch[1], m_ch[0]};
		pal[3] = gt_s1 ? {8'hFF, n_ch[2], n_ch[1], n_ch[0]} : 32'd0;
	end

	always_comb begin
		q_data.pal   = pal;
		q_data.sel   = sel_s1;
		q_data.x0    = x0_s1;
		q_data.y0    = y0_s1;
		q_data.mask  = mask;
		q_data.nrows = {2'b00, row_in[0]} + {2'b00, row_in[1]}
			+ {2'b00, row_in[2]} + {2'b00, row_in[3]};
	end

endmodule

`default_nettype wire

// ===== sv/bc1d_queue.sv =====
// Two-entry queue between the front end and the row sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bc1d_queue
	import bc1d_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire bc1d_entry_t wr_data,
	output logic        q_full,
	input  wire logic   rd_en,
	output bc1d_entry_t rd_data,
	output logic        q_empty
);

	bc1d_entry_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign q_full  = count_q == 2'd2;
	assign q_empty = count_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bc1d_back.sv =====
// Row sequencer: walks the rows of the queued block and fills the result register.
`timescale 1ns / 1ps
`default_nettype none

module bc1d_back
	import bc1d_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire bc1d_entry_t head,
	input  wire logic   q_empty,
	output logic        q_pop,
	output logic        empty,
	input  wire logic   pop,
	output logic [12:0] texel_y,
	output logic [12:0] texel_x_base,
	output logic [3:0][31:0] texels,
	output logic [3:0]  column_mask,
	output logic        last_row
);

	logic             out_valid_q;
	logic [1:0]       row_q;
	logic             advance;
	logic             none;
	logic             last;
	logic [7:0]       row_sel;
	logic [3:0][31:0] tex_d;
	logic [1:0]       idx;

	assign empty   = ~out_valid_q;
	assign advance = (~out_valid_q | pop) & ~q_empty;
	assign q_pop   = advance & last;

	always_comb begin
		none    = head.nrows == 3'd0;
		last    = none || (({1'b0, row_q} + 3'd1) == head.nrows);
		row_sel = head.sel[{row_q, 3'b000} +: 8];
		idx     = 2'b00;
		for (int i = 0; i < 4; i++) begin
			idx      = row_sel[2*i +: 2];
			tex_d[i] = (head.mask[i] & ~none) ? head.pal[idx] : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			row_q       <= 2'd0;
		end else begin
			out_valid_q <= advance | (out_valid_q & ~pop);
			if (advance) begin
				row_q <= last ? 2'd0 : row_q + 2'd1;
			end
		end
	end

	// hold the word until it is popped
	always_ff @(posedge clk) begin
		if (advance) begin
			texel_y      <= {head.y0[12:2], row_q};
			texel_x_base <= head.x0;
			texels       <= tex_d;
			column_mask  <= none ? 4'd0 : head.mask;
			last_row     <= last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bc1_block_decoder.sv =====
// Top level of the BC1 block decoder: configuration registers and the front/back split.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted block word yields one result word per texel row that lies inside the
// image height, top to bottom, and a single empty word when no row lies inside; a full
// block yields four words, one per row, made by the row sequencer behind the queue. The
// front end takes a new block every cycle while the queue has room, so back-to-back
// blocks stream at one result word per cycle while the result words are popped. With the
// pipeline idle, the first word of a block passes the front-end register, the queue and
// the result register before it is on the result ports. Image width and height reset to
// 8192 and saturate at MAX_DIM; write them only while the decoder is idle.
module bc1_block_decoder
	import bc1d_pkg::*;
#(
	parameter int unsigned MAX_DIM = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [13:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] endpoint_a,
	input  wire logic [15:0] endpoint_b,
	input  wire logic [31:0] selector_bits,
	input  wire logic [10:0] block_col,
	input  wire logic [10:0] block_row,
	output logic             empty,
	input  wire logic        pop,
	output logic [12:0]      texel_y,
	output logic [12:0]      texel_x_base,
	output logic [31:0]      texel_0,
	output logic [31:0]      texel_1,
	output logic [31:0]      texel_2,
	output logic [31:0]      texel_3,
	output logic [3:0]       column_mask,
	output logic             last_row
);

	localparam logic       RegImageWidth  = 1'b0;
	localparam logic       RegImageHeight = 1'b1;
	localparam logic [13:0] DimReset      = 14'd8192;

	logic [13:0]      width_q;
	logic [13:0]      height_q;
	bc1d_entry_t      q_wr_data;
	bc1d_entry_t      q_rd_data;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	logic [3:0][31:0] texels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimReset;
			height_q <= DimReset;
		end else if (cfg_write) begin
			case (cfg_index)
				RegImageWidth:  width_q  <= cfg_data;
				RegImageHeight: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bc1d_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.endpoint_a   (endpoint_a),
		.endpoint_b   (endpoint_b),
		.selector_bits(selector_bits),
		.block_col    (block_col),
		.block_row    (block_row),
		.width_cfg    (width_q),
		.height_cfg   (height_q),
		.q_data       (q_wr_data),
		.q_push       (q_push),
		.q_full       (q_full)
	);

	bc1d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr_data),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.q_empty(q_empty)
	);

	bc1d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_rd_data),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.texel_y     (texel_y),
		.texel_x_base(texel_x_base),
		.texels      (texels),
		.column_mask (column_mask),
		.last_row    (last_row)
	);

	assign texel_0 = texels[0];
	assign texel_1 = texels[1];
	assign texel_2 = texels[2];
	assign texel_3 = texels[3];

endmodule

`default_nettype wire
